// ===== src/sorted_segment_pooling_unit_defines.svh =====
// Assertion helpers used by the checker file ssp_checker.sv.
`ifndef SORTED_SEGMENT_POOLING_UNIT_DEFINES_SVH
`define SORTED_SEGMENT_POOLING_UNIT_DEFINES_SVH

// same-cycle implication
`define SSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/ssp_pkg.sv =====
package ssp_pkg;

  localparam int MAX_ROW_WIDTH = 16;
  localparam int COL_W         = 6;
  localparam int ID_W          = 32;
  localparam int VAL_W         = 32;
  localparam int ACC_W         = 64;
  localparam int ROWS_W        = 32;
  localparam int CMD_DEPTH     = 2;
  localparam int DIV_STEPS     = 64;
  localparam int IN_DATA_W     = 64;
  localparam int OUT_DATA_W    = 72;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_SEGMENT = 2'd2;

  typedef enum logic [1:0] {
    MODE_SUM  = 2'd0,
    MODE_MEAN = 2'd1,
    MODE_MAX  = 2'd2,
    MODE_MIN  = 2'd3
  } pool_mode_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ERR,
    B_FLUSH,
    B_DIV,
    B_SIGN,
    B_EMIT,
    B_ACCUM
  } back_state_e;

  // One command per accepted element: optional flush of the old segment,
  // the column update, optional flush at end of input. err replaces all.
  typedef struct packed {
    logic                     err;
    logic [ID_W-1:0]          err_id;
    logic                     pre_flush;
    logic [ID_W-1:0]          pre_seg;
    logic [ROWS_W-1:0]        pre_rows;
    logic [COL_W-1:0]         col;
    logic signed [VAL_W-1:0]  value;
    logic                     first;
    logic                     post_flush;
    logic [ID_W-1:0]          post_seg;
    logic [ROWS_W-1:0]        post_rows;
  } cmd_t;

endpackage

// ===== src/ssp_front.sv =====
module ssp_front
  import ssp_pkg::*;
#(
  parameter int MaxRowWidth = MAX_ROW_WIDTH,
  localparam int WidthW = $clog2(MaxRowWidth + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ID_W-1:0]         seg_id_i,
  input  logic signed [VAL_W-1:0] elem_value_i,
  input  logic                    final_elem_i,
  input  logic [WidthW-1:0]       eff_width_i,
  input  logic                    single_segment_i,
  input  logic                    cmd_full_i,
  output logic                    cmd_push_o,
  output cmd_t                    cmd_o
);

  logic [ID_W-1:0]   cur_q, cur_d;
  logic [ROWS_W-1:0] rows_q, rows_d;
  logic [COL_W-1:0]  col_pos_q, col_pos_d;
  logic              open_q, open_d;

  logic [COL_W:0]    w_ext;
  logic [COL_W-1:0]  col;
  logic              row_start, is_err, is_pre, new_seg, last_col, is_post;
  logic [ID_W-1:0]   id, cur_n;
  logic [ROWS_W-1:0] rows_base, rows_n;

  assign in_ready_o = !cmd_full_i;
  assign cmd_push_o = in_valid_i && !cmd_full_i;

  always_comb begin
    w_ext     = (COL_W+1)'(eff_width_i);
    col       = ({1'b0, col_pos_q} >= w_ext) ? '0 : col_pos_q;
    row_start = (col == '0);
    id        = single_segment_i ? '0 : seg_id_i;
    is_err    = row_start && open_q && (id < cur_q);
    is_pre    = row_start && open_q && (id > cur_q);
    new_seg   = row_start && (!open_q || is_pre);
    cur_n     = new_seg ? id : cur_q;
    rows_base = new_seg ? '0 : rows_q;
    if (row_start) begin
      rows_n = (rows_base == '1) ? rows_base : rows_base + 1'b1;
    end else begin
      rows_n = rows_q;
    end
    last_col = (({1'b0, col}) + 1'b1) >= w_ext;
    is_post  = last_col && final_elem_i;

    cmd_o.err        = is_err;
    cmd_o.err_id     = id;
    cmd_o.pre_flush  = is_pre;
    cmd_o.pre_seg    = cur_q;
    cmd_o.pre_rows   = rows_q;
    cmd_o.col        = col;
    cmd_o.value      = elem_value_i;
    cmd_o.first      = (rows_n <= ROWS_W'(1));
    cmd_o.post_flush = is_post;
    cmd_o.post_seg   = cur_n;
    cmd_o.post_rows  = rows_n;

    cur_d     = cur_q;
    rows_d    = rows_q;
    col_pos_d = col_pos_q;
    open_d    = open_q;
    if (cmd_push_o) begin
      if (is_err) begin
        cur_d     = '0;
        rows_d    = '0;
        col_pos_d = '0;
        open_d    = 1'b0;
      end else begin
        cur_d     = cur_n;
        rows_d    = is_post ? '0 : rows_n;
        col_pos_d = last_col ? '0 : col + 1'b1;
        open_d    = !is_post;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q     <= '0;
      rows_q    <= '0;
      col_pos_q <= '0;
      open_q    <= 1'b0;
    end else begin
      cur_q     <= cur_d;
      rows_q    <= rows_d;
      col_pos_q <= col_pos_d;
      open_q    <= open_d;
    end
  end

endmodule

// ===== src/ssp_cmd_fifo.sv =====
module ssp_cmd_fifo
  import ssp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t head_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PtrW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int CntW = $clog2(CMD_DEPTH + 1);

  cmd_t            mem_q [CMD_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/ssp_back.sv =====
module ssp_back
  import ssp_pkg::*;
#(
  parameter int MaxRowWidth = MAX_ROW_WIDTH,
  localparam int WidthW = $clog2(MaxRowWidth + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_empty_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  pool_mode_e            pool_mode_i,
  input  logic [WidthW-1:0]     eff_width_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_segment, out_column, pooled_value
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser   // status
);

  localparam int IdxW   = (MaxRowWidth > 1) ? $clog2(MaxRowWidth) : 1;
  localparam int StepW  = $clog2(DIV_STEPS);
  localparam int PadW   = OUT_DATA_W - ID_W - COL_W - VAL_W;

  function automatic logic [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [VAL_W-1:0] r;
    if (v > ACC_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
      r = {1'b0, {(VAL_W-1){1'b1}}};
    end else if (v < -(ACC_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) - 1) begin
      r = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  back_state_e state_q, state_d;

  // accumulators; an entry without its valid bit reads as zero
  logic signed [ACC_W-1:0] acc_q [MaxRowWidth];
  logic [MaxRowWidth-1:0]  acc_vld_q;

  cmd_t                    cmd_q;
  logic [ID_W-1:0]         fl_seg_q;
  logic [ROWS_W-1:0]       fl_rows_q;
  logic                    fl_post_q;
  logic [COL_W-1:0]        c_q;
  logic signed [ACC_W-1:0] res_q;

  logic [ACC_W-1:0]        quo_q;
  logic [ROWS_W-1:0]       rem_q;
  logic [StepW-1:0]        step_q;
  logic                    neg_q;

  logic                    out_valid_q;
  logic [ID_W-1:0]         out_seg_q;
  logic [COL_W-1:0]        out_col_q;
  logic [VAL_W-1:0]        out_val_q;
  logic                    out_last_q;
  logic                    out_status_q;

  logic                    out_free, flush_last, use_div, out_load, clear_all;
  logic [IdxW-1:0]         c_idx, a_idx;
  logic signed [ACC_W-1:0] rd_val, old_val, v64, new_val;
  logic signed [ACC_W:0]   sum65;
  logic [ROWS_W:0]         rem_sh;
  logic                    rem_ge;

  assign out_free   = !out_valid_q || m_axis_tready;
  assign c_idx      = c_q[IdxW-1:0];
  assign a_idx      = cmd_q.col[IdxW-1:0];
  assign rd_val     = acc_vld_q[c_idx] ? acc_q[c_idx] : '0;
  assign old_val    = acc_vld_q[a_idx] ? acc_q[a_idx] : '0;
  assign flush_last = (({1'b0, c_q}) + 1'b1) == (COL_W+1)'(eff_width_i);
  assign use_div    = (pool_mode_i == MODE_MEAN) && (fl_rows_q != '0);
  assign v64        = ACC_W'(cmd_q.value);
  assign sum65      = {old_val[ACC_W-1], old_val} + {v64[ACC_W-1], v64};
  assign rem_sh     = {rem_q, quo_q[ACC_W-1]};
  assign rem_ge     = rem_sh >= {1'b0, fl_rows_q};

  always_comb begin
    if (cmd_q.first) begin
      new_val = v64;
    end else begin
      case (pool_mode_i)
        MODE_MAX: new_val = (v64 > old_val) ? v64 : old_val;
        MODE_MIN: new_val = (v64 < old_val) ? v64 : old_val;
        default: begin
          if (sum65[ACC_W] != sum65[ACC_W-1]) begin
            new_val = sum65[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
          end else begin
            new_val = sum65[ACC_W-1:0];
          end
        end
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    out_load  = 1'b0;
    clear_all = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.err) begin
            state_d = B_ERR;
          end else if (cmd_i.pre_flush) begin
            state_d = B_FLUSH;
          end else begin
            state_d = B_ACCUM;
          end
        end
      end
      B_ERR: begin
        if (out_free) begin
          out_load  = 1'b1;
          clear_all = 1'b1;
          state_d   = B_IDLE;
        end
      end
      B_FLUSH: state_d = use_div ? B_DIV : B_EMIT;
      B_DIV: begin
        if (step_q == StepW'(DIV_STEPS - 1)) begin
          state_d = B_SIGN;
        end
      end
      B_SIGN: state_d = B_EMIT;
      B_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (flush_last) begin
            clear_all = 1'b1;
            state_d   = fl_post_q ? B_IDLE : B_ACCUM;
          end else begin
            state_d = B_FLUSH;
          end
        end
      end
      B_ACCUM: state_d = cmd_q.post_flush ? B_FLUSH : B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      acc_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (clear_all) begin
        acc_vld_q <= '0;
      end else if (state_q == B_ACCUM) begin
        acc_vld_q[a_idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q     <= cmd_i;
      fl_seg_q  <= cmd_i.pre_seg;
      fl_rows_q <= cmd_i.pre_rows;
      fl_post_q <= 1'b0;
      c_q       <= '0;
    end
    if (state_q == B_ACCUM) begin
      acc_q[a_idx] <= new_val;
      fl_seg_q     <= cmd_q.post_seg;
      fl_rows_q    <= cmd_q.post_rows;
      fl_post_q    <= 1'b1;
      c_q          <= '0;
    end
    if (state_q == B_FLUSH) begin
      res_q  <= rd_val;
      neg_q  <= rd_val[ACC_W-1];
      quo_q  <= rd_val[ACC_W-1] ? (~rd_val + 1'b1) : rd_val;
      rem_q  <= '0;
      step_q <= '0;
    end
    if (state_q == B_DIV) begin
      // restoring division, one quotient bit per cycle
      quo_q  <= {quo_q[ACC_W-2:0], rem_ge};
      rem_q  <= rem_ge ? ROWS_W'(rem_sh - {1'b0, fl_rows_q}) : rem_sh[ROWS_W-1:0];
      step_q <= step_q + 1'b1;
    end
    if (state_q == B_SIGN) begin
      res_q <= neg_q ? (~quo_q + 1'b1) : quo_q;
    end
    if (state_q == B_EMIT && out_free && !flush_last) begin
      c_q <= c_q + 1'b1;
    end
    if (out_load) begin
      if (state_q == B_ERR) begin
        out_seg_q    <= cmd_q.err_id;
        out_col_q    <= '0;
        out_val_q    <= '0;
        out_last_q   <= 1'b1;
        out_status_q <= 1'b1;
      end else begin
        out_seg_q    <= fl_seg_q;
        out_col_q    <= c_q;
        out_val_q    <= sat32(res_q);
        out_last_q   <= flush_last;
        out_status_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_val_q, out_col_q, out_seg_q};
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// ===== src/sorted_segment_pooling_unit.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata: seg_id, elem_value; tlast: final_elem
// m_axis    out        tdata: out_segment, out_column, pooled_value; tlast: run_last;
//                      tuser: status
// cfg       in         write-only: pool_mode, row_width, single_segment
//
// For an element the back pops its command in B_IDLE, then updates the column in B_ACCUM.
// Flush: each column passes B_FLUSH and B_EMIT; mean mode adds B_DIV (one quotient bit per cycle) and B_SIGN.
// The 2-entry command queue lets the front keep taking elements while the back flushes, until it is full.
// Reset is asynchronous, active low; no clearing pass, the accumulators have valid bits.
// The output register holds a result until taken and the back stalls behind it.
module sorted_segment_pooling_unit
  import ssp_pkg::*;
#(
  parameter int MaxRowWidth = MAX_ROW_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // seg_id, elem_value
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // out_segment, out_column, pooled_value, pad
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser,  // status
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int WidthW = $clog2(MaxRowWidth + 1);

  pool_mode_e          mode_q;
  logic [4:0]          width_q;
  logic                single_q;
  logic [WidthW-1:0]   eff_width;

  cmd_t                cmd_in, cmd_head;
  logic                cmd_push, cmd_pop, cmd_full, cmd_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SUM;
      width_q  <= 5'd1;
      single_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POOL_MODE:      mode_q   <= pool_mode_e'(cfg_wdata_i[1:0]);
        REG_ROW_WIDTH:      width_q  <= cfg_wdata_i[4:0];
        REG_SINGLE_SEGMENT: single_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(width_q) > MaxRowWidth) begin
      eff_width = WidthW'(MaxRowWidth);
    end else if (width_q == '0) begin
      eff_width = WidthW'(1);
    end else begin
      eff_width = WidthW'(width_q);
    end
  end

  ssp_front #(
    .MaxRowWidth(MaxRowWidth)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .seg_id_i        (s_axis_tdata[ID_W-1:0]),
    .elem_value_i    (s_axis_tdata[ID_W+VAL_W-1:ID_W]),
    .final_elem_i    (s_axis_tlast),
    .eff_width_i     (eff_width),
    .single_segment_i(single_q),
    .cmd_full_i      (cmd_full),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in)
  );

  ssp_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (cmd_in),
    .pop_i  (cmd_pop),
    .head_o (cmd_head),
    .full_o (cmd_full),
    .empty_o(cmd_empty)
  );

  ssp_back #(
    .MaxRowWidth(MaxRowWidth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_head),
    .cmd_pop_o    (cmd_pop),
    .pool_mode_i  (mode_q),
    .eff_width_i  (eff_width),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule

// ===== src/ssp_checker.sv =====
`include "sorted_segment_pooling_unit_defines.svh"

module ssp_checker
  import ssp_pkg::*;
#(
  parameter int MaxRowWidth = MAX_ROW_WIDTH
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast,
  input logic                  m_axis_tuser
);

  `SSP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled result changed")
  `SSP_ASSERT_IMP(a_err_shape, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tlast && (m_axis_tdata[OUT_DATA_W-1:ID_W] == '0), "error result malformed")
  `SSP_ASSERT_IMP(a_err_alone, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !m_axis_tuser, "error result inside a run")
  `SSP_ASSERT_IMP(a_col_range, clk_i, rst_ni, m_axis_tvalid, (int'(m_axis_tdata[ID_W+COL_W-1:ID_W]) < MaxRowWidth) && (m_axis_tdata[OUT_DATA_W-1:ID_W+COL_W+VAL_W] == '0), "column out of range")

endmodule

bind sorted_segment_pooling_unit ssp_checker #(
  .MaxRowWidth(MaxRowWidth)
) u_ssp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
